// ===== design/lru_fully_associative_tlb_unit_defines.svh =====
// Assertion macros shared by the translation buffer modules.
`ifndef LRU_FULLY_ASSOCIATIVE_TLB_UNIT_DEFINES_SVH
`define LRU_FULLY_ASSOCIATIVE_TLB_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LRUTLB_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LRUTLB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lrutlb_pkg.sv =====
// Shared widths, codes and link types of the translation buffer.
`timescale 1ns / 1ps

package lrutlb_pkg;

    localparam int PAGE_W      = 36;
    localparam int PID_W       = 16;
    localparam int FRAME_W     = 36;
    localparam int DEF_ENTRIES = 16;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_LOOKUP = 2'b10
    } t_state;

    // What one cell shows its neighbours: its entry and its marks.
    typedef struct packed {
        logic               valid;
        logic [PAGE_W-1:0]  page;
        logic [PID_W-1:0]   pid;
        logic [FRAME_W-1:0] frame;
        logic               tok;
        logic               bub;
        logic               miss;
    } t_link;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic              shift;
        logic              clr;
        logic [PAGE_W-1:0] page;
        logic [PID_W-1:0]  pid;
    } t_ctl;

    localparam t_link LINK_IDLE = '0;

endpackage

// ===== design/lrutlb_if.sv =====
// Request and response channel interfaces of the translation buffer.
`timescale 1ns / 1ps

interface lrutlb_req_if import lrutlb_pkg::*;;
    logic               valid;
    logic               ready;
    logic               action;
    logic [PAGE_W-1:0]  virt_page;
    logic [PID_W-1:0]   proc_id;
    logic [FRAME_W-1:0] new_frame;

    modport source (output valid, output action, output virt_page, output proc_id,
                    output new_frame, input ready);
    modport sink   (input valid, input action, input virt_page, input proc_id,
                    input new_frame, output ready);
endinterface

interface lrutlb_rsp_if import lrutlb_pkg::*;;
    logic               valid;
    logic               ready;
    logic               hit;
    logic [FRAME_W-1:0] phys_frame;

    modport source (output valid, output hit, output phys_frame, input ready);
    modport sink   (input valid, input hit, input phys_frame, output ready);
endinterface

// ===== design/lrutlb_cell.sv =====
// One slot of the recency chain: entry, compare, search token and move marks.
`timescale 1ns / 1ps
`include "lru_fully_associative_tlb_unit_defines.svh"

module lrutlb_cell import lrutlb_pkg::*; #(
    parameter bit IS_FIRST = 1'b0,
    parameter bit IS_LAST  = 1'b0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ctl  i_ctl,
    input  t_link i_prev,
    input  t_link i_next,
    output t_link o_link
);

    logic               r_valid;
    logic [PAGE_W-1:0]  r_page;
    logic [PID_W-1:0]   r_pid;
    logic [FRAME_W-1:0] r_frame;
    logic               r_tok;
    logic               r_bub;
    logic               r_miss;

    logic               n_valid;
    logic [PAGE_W-1:0]  n_page;
    logic [PID_W-1:0]   n_pid;
    logic [FRAME_W-1:0] n_frame;
    logic               n_tok;
    logic               n_bub;
    logic               n_miss;

    logic w_eq;
    logic w_hit;
    logic w_miss;
    logic w_take_prev;
    logic w_take_next;

    assign w_eq   = r_valid && (r_page == i_ctl.page) && (r_pid == i_ctl.pid);
    assign w_hit  = r_tok && w_eq;
    // search ends here: empty slot, or the last slot without a match
    assign w_miss = r_tok && !w_eq && (!r_valid || IS_LAST);

    // a hit bubble swaps with the slot ahead each cycle until it reaches the front
    assign w_take_prev = i_ctl.shift || (!IS_FIRST && r_bub);
    assign w_take_next = !i_ctl.shift && i_next.bub;

    always_comb begin
        n_valid = r_valid;
        n_page  = r_page;
        n_pid   = r_pid;
        n_frame = r_frame;
        if (w_take_prev) begin
            n_valid = i_prev.valid;
            n_page  = i_prev.page;
            n_pid   = i_prev.pid;
            n_frame = i_prev.frame;
        end else if (w_take_next) begin
            n_valid = i_next.valid;
            n_page  = i_next.page;
            n_pid   = i_next.pid;
            n_frame = i_next.frame;
        end
    end

    assign n_tok  = i_prev.tok;
    assign n_bub  = w_hit || i_next.bub || (IS_FIRST && r_bub && !i_ctl.clr);
    assign n_miss = w_miss || i_next.miss || (IS_FIRST && r_miss && !i_ctl.clr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= 1'b0;
            r_bub   <= 1'b0;
            r_miss  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
            r_bub   <= n_bub;
            r_miss  <= n_miss;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page  <= n_page;
        r_pid   <= n_pid;
        r_frame <= n_frame;
    end

    always_comb begin
        o_link.valid = r_valid;
        o_link.page  = r_page;
        o_link.pid   = r_pid;
        o_link.frame = r_frame;
        o_link.tok   = r_tok && r_valid && !w_eq;
        o_link.bub   = r_bub;
        o_link.miss  = r_miss;
    end

    `LRUTLB_ASSERT_IMPL(a_tok_alone, r_tok, !r_bub && !r_miss, "search token meets a move mark")
    `LRUTLB_ASSERT_NEXT(a_tok_moves, r_tok, !r_tok, "search token stalls in a slot")
    `LRUTLB_ASSERT_NEXT(a_bub_moves, r_bub && !IS_FIRST, !r_bub, "hit bubble stalls behind front")

endmodule

// ===== design/lrutlb_ctrl.sv =====
// Channel control: request decode, lookup sequencing and result register.
`timescale 1ns / 1ps
`include "lru_fully_associative_tlb_unit_defines.svh"

module lrutlb_ctrl import lrutlb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lrutlb_req_if.sink   i_req,
    lrutlb_rsp_if.source o_rsp,
    input  t_link i_head,
    output t_link o_head,
    output t_ctl  o_ctl
);

    t_state r_state;
    t_state n_state;

    logic [PAGE_W-1:0]  r_key_page;
    logic [PID_W-1:0]   r_key_pid;
    logic               r_out_valid;
    logic               r_out_hit;
    logic [FRAME_W-1:0] r_out_frame;

    logic w_accept;
    logic w_insert;
    logic w_lookup;
    logic w_reply;

    assign w_reply  = (r_state == ST_LOOKUP) && (i_head.bub || i_head.miss)
                      && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = (r_state == ST_IDLE) || w_reply;
    assign w_accept = i_req.valid && i_req.ready;
    assign w_insert = w_accept && (i_req.action == ACT_INSERT);
    assign w_lookup = w_accept && (i_req.action == ACT_LOOKUP);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_lookup) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (w_reply) begin
                    n_state = w_lookup ? ST_LOOKUP : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_reply) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lookup) begin
            r_key_page <= i_req.virt_page;
            r_key_pid  <= i_req.proc_id;
        end
        if (w_reply) begin
            r_out_hit   <= i_head.bub;
            r_out_frame <= i_head.bub ? i_head.frame : '0;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.phys_frame = r_out_frame;

    always_comb begin
        o_head.valid = 1'b1;
        o_head.page  = i_req.virt_page;
        o_head.pid   = i_req.proc_id;
        o_head.frame = i_req.new_frame;
        o_head.tok   = w_lookup;
        o_head.bub   = 1'b0;
        o_head.miss  = 1'b0;
        o_ctl.shift  = w_insert;
        o_ctl.clr    = w_reply;
        o_ctl.page   = r_key_page;
        o_ctl.pid    = r_key_pid;
    end

    `LRUTLB_ASSERT_IMPL(a_head_excl, 1'b1, !(i_head.bub && i_head.miss), "hit and miss at front")
    `LRUTLB_ASSERT_IMPL(a_idle_quiet, r_state == ST_IDLE, !i_head.bub && !i_head.miss, "mark while idle")
    `LRUTLB_ASSERT_NEXT(a_reply_load, w_reply, r_out_valid, "result not registered")
    `LRUTLB_ASSERT_NEXT(a_miss_zero, w_reply && i_head.miss, !r_out_hit && (r_out_frame == '0), "bad miss result")

endmodule

// ===== design/lru_fully_associative_tlb_unit.sv =====
// Fully associative translation buffer with least-recently-used replacement.
// Entries sit in a chain of ENTRIES cells in recency order, most recent in cell 0,
// and valid entries always fill a prefix of the chain. On an insert the whole chain
// shifts back one cell, the last entry drops off, and the new one enters cell 0;
// it gives no result. A lookup sends a search token down the chain, one cell per
// cycle. On a hit in cell k the entry bubbles back to cell 0 by swapping with its
// neighbour once a cycle; on a miss a mark walks back the same way. The result is
// registered once the bubble or the mark reaches cell 0 and the previous result
// has been transferred. No request is taken while a lookup is open; the next one
// is taken in the cycle its result is registered. Duplicate inserts are kept: the
// newest one answers.
`timescale 1ns / 1ps

module lru_fully_associative_tlb_unit import lrutlb_pkg::*; #(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input logic i_clk,
    input logic i_rst_n,
    lrutlb_req_if.sink   i_req,
    lrutlb_rsp_if.source o_rsp
);

    t_link w_head;
    t_ctl  w_ctl;
    t_link w_cell [ENTRIES];

    lrutlb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_head  (w_cell[0]),
        .o_head  (w_head),
        .o_ctl   (w_ctl)
    );

    for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
        t_link w_prev;
        t_link w_next;

        if (gi == 0) begin : g_first
            assign w_prev = w_head;
        end else begin : g_mid
            assign w_prev = w_cell[gi-1];
        end

        if (gi == ENTRIES - 1) begin : g_last
            assign w_next = LINK_IDLE;
        end else begin : g_body
            assign w_next = w_cell[gi+1];
        end

        lrutlb_cell #(
            .IS_FIRST (gi == 0),
            .IS_LAST  (gi == ENTRIES - 1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_link  (w_cell[gi])
        );
    end

endmodule
